### rtl/pcwd_pkg.sv
// ----------------------------------------------------------------------------
// pcwd_pkg
// Shared constants and types for the per-channel weight dequantizer.
// ----------------------------------------------------------------------------
package pcwd_pkg;

  localparam int unsigned MaxChannels = 1024;
  localparam int unsigned TblAw       = $clog2(MaxChannels);
  localparam int unsigned InnerMax    = 1048576;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned BitsW   = 4;
  localparam int unsigned ChanW   = 11;
  localparam int unsigned InnerW  = 21;
  localparam int unsigned CfgW    = 21;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned ScaleW  = 32;
  localparam int unsigned WeightW = 8;
  localparam int unsigned ResW    = 40;
  localparam int unsigned IposW   = 20;
  localparam int unsigned CposW   = 10;

  // divider: dividend is the Q16.16 scale shifted up by 8
  localparam int unsigned DivW    = ScaleW + 8;
  localparam int unsigned DivisW  = 15;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic [CfgIdxW-1:0] CFG_MODE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BITS     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHANNELS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_INNER    = 2'd3;

  localparam logic [ModeW-1:0] MODE_PER_LAYER = 2'd0;

  localparam logic KIND_SCALE  = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

  typedef struct packed {
    logic capture;  // latch input transaction, advance counters on weights
    logic div_step; // one quotient bit
    logic mem_wr;   // store saturated quotient
    logic mem_rd;   // fetch selected scale
    logic out_load; // load product into output register
  } cmd_t;

  typedef struct packed {
    logic div_last;  // final quotient bit this step
    logic out_ready; // output register can take a product
  } status_t;

endpackage

### rtl/pcwd_ctrl.sv
// ----------------------------------------------------------------------------
// pcwd_ctrl
// Sequencer: accepts transactions and steps the datapath through fetch,
// multiply, divide and table write.
// ----------------------------------------------------------------------------
module pcwd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              kind_i,
  input  pcwd_pkg::status_t status_i,
  output logic              in_stall_o,
  output pcwd_pkg::cmd_t    cmd_o
);

  pcwd_pkg::state_e state_d, state_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      pcwd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (kind_i == pcwd_pkg::KIND_WEIGHT) ? pcwd_pkg::ST_READ
                                                      : pcwd_pkg::ST_DIV;
        end
      end
      pcwd_pkg::ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = pcwd_pkg::ST_MUL;
      end
      pcwd_pkg::ST_MUL: begin
        if (status_i.out_ready) begin
          cmd_o.out_load = 1'b1;
          state_d        = pcwd_pkg::ST_IDLE;
        end
      end
      pcwd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = pcwd_pkg::ST_WRITE;
      end
      pcwd_pkg::ST_WRITE: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = pcwd_pkg::ST_IDLE;
      end
      default: state_d = pcwd_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != pcwd_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcwd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/pcwd_datapath.sv
// ----------------------------------------------------------------------------
// pcwd_datapath
// Config registers, channel counters, scale table, bit-serial divider,
// multiplier and output register.
// ----------------------------------------------------------------------------
module pcwd_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pcwd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pcwd_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                kind_i,
  input  logic [9:0]                          scale_index_i,
  input  logic [pcwd_pkg::ScaleW-1:0]         scale_value_i,
  input  logic signed [pcwd_pkg::WeightW-1:0] weight_i,
  input  logic                                last_i,
  input  logic                                out_stall_i,
  input  pcwd_pkg::cmd_t                      cmd_i,
  output pcwd_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  output logic signed [pcwd_pkg::ResW-1:0]    dequantized_o,
  output logic                                last_res_o
);

  // config
  logic [pcwd_pkg::ModeW-1:0]  mode_q;
  logic [pcwd_pkg::BitsW-1:0]  bits_q;
  logic [pcwd_pkg::ChanW-1:0]  chans_q;
  logic [pcwd_pkg::InnerW-1:0] inner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pcwd_pkg::MODE_PER_LAYER;
      bits_q  <= pcwd_pkg::BitsW'(8);
      chans_q <= pcwd_pkg::ChanW'(1);
      inner_q <= pcwd_pkg::InnerW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcwd_pkg::CFG_MODE:     mode_q  <= cfg_data_i[pcwd_pkg::ModeW-1:0];
        pcwd_pkg::CFG_BITS:     bits_q  <= cfg_data_i[pcwd_pkg::BitsW-1:0];
        pcwd_pkg::CFG_CHANNELS: chans_q <= cfg_data_i[pcwd_pkg::ChanW-1:0];
        pcwd_pkg::CFG_INNER:    inner_q <= cfg_data_i[pcwd_pkg::InnerW-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [pcwd_pkg::ChanW-1:0]  eff_chans;
  logic [pcwd_pkg::InnerW-1:0] eff_inner;
  logic [pcwd_pkg::BitsW-1:0]  eff_bits;
  logic [pcwd_pkg::DivisW-1:0] divisor;

  always_comb begin
    priority if (chans_q == '0) eff_chans = pcwd_pkg::ChanW'(1);
    else if (chans_q > pcwd_pkg::ChanW'(pcwd_pkg::MaxChannels))
      eff_chans = pcwd_pkg::ChanW'(pcwd_pkg::MaxChannels);
    else eff_chans = chans_q;

    priority if (inner_q == '0) eff_inner = pcwd_pkg::InnerW'(1);
    else if (inner_q > pcwd_pkg::InnerW'(pcwd_pkg::InnerMax))
      eff_inner = pcwd_pkg::InnerW'(pcwd_pkg::InnerMax);
    else eff_inner = inner_q;

    eff_bits = (bits_q < pcwd_pkg::BitsW'(2)) ? pcwd_pkg::BitsW'(2) : bits_q;
    divisor  = (pcwd_pkg::DivisW'(1) << (eff_bits - pcwd_pkg::BitsW'(1)))
               - pcwd_pkg::DivisW'(1);
  end

  // channel counters
  logic [pcwd_pkg::IposW-1:0] ipos_d, ipos_q, ipos_inc;
  logic [pcwd_pkg::CposW-1:0] cpos_d, cpos_q, cpos_inc;
  logic [pcwd_pkg::TblAw-1:0] sel;

  always_comb begin
    ipos_inc = ipos_q + pcwd_pkg::IposW'(1);
    cpos_inc = cpos_q + pcwd_pkg::CposW'(1);
    ipos_d   = ipos_q;
    cpos_d   = cpos_q;
    if (cmd_i.capture && kind_i == pcwd_pkg::KIND_WEIGHT) begin
      if (last_i) begin
        ipos_d = '0;
        cpos_d = '0;
      end else if (ipos_inc == '0 || {1'b0, ipos_inc} >= eff_inner) begin
        ipos_d = '0;
        cpos_d = ({1'b0, cpos_inc} >= eff_chans) ? '0 : cpos_inc;
      end else begin
        ipos_d = ipos_inc;
      end
    end
    // stale position (count lowered mid-tensor) falls back to scale 0
    if (mode_q != pcwd_pkg::MODE_PER_LAYER && {1'b0, cpos_q} < eff_chans)
      sel = pcwd_pkg::TblAw'(cpos_q);
    else
      sel = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipos_q <= '0;
      cpos_q <= '0;
    end else begin
      ipos_q <= ipos_d;
      cpos_q <= cpos_d;
    end
  end

  // captured transaction
  logic [pcwd_pkg::TblAw-1:0]          addr_q;
  logic                                wr_ok_q;
  logic signed [pcwd_pkg::WeightW-1:0] weight_q;
  logic                                last_q;

  // divider: quotient bits shift into the dividend register
  logic [pcwd_pkg::DivW-1:0]    quo_q;
  logic [pcwd_pkg::DivisW-1:0]  rem_q;
  logic [pcwd_pkg::DivCntW-1:0] cnt_q;
  logic [pcwd_pkg::DivisW:0]    rem_sh;
  logic                         qbit;

  always_comb begin
    rem_sh = {rem_q, quo_q[pcwd_pkg::DivW-1]};
    qbit   = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q   <= (kind_i == pcwd_pkg::KIND_WEIGHT) ? sel
                                                    : pcwd_pkg::TblAw'(scale_index_i);
      wr_ok_q  <= ({1'b0, scale_index_i} < 11'(pcwd_pkg::MaxChannels));
      weight_q <= weight_i;
      last_q   <= last_i;
      quo_q    <= {scale_value_i, 8'b0};
      rem_q    <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[pcwd_pkg::DivW-2:0], qbit};
      rem_q <= qbit ? pcwd_pkg::DivisW'(rem_sh - {1'b0, divisor})
                    : rem_sh[pcwd_pkg::DivisW-1:0];
      cnt_q <= cnt_q + pcwd_pkg::DivCntW'(1);
    end
  end

  assign status_o.div_last = (cnt_q == pcwd_pkg::DivCntW'(pcwd_pkg::DivW - 1));

  // scale table, Q8.24
  logic [pcwd_pkg::ScaleW-1:0] mem [pcwd_pkg::MaxChannels];
  logic [pcwd_pkg::ScaleW-1:0] scale_q;
  logic [pcwd_pkg::ScaleW-1:0] quo_sat;

  assign quo_sat = (quo_q[pcwd_pkg::DivW-1:pcwd_pkg::ScaleW] != '0) ? '1
                 : quo_q[pcwd_pkg::ScaleW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && wr_ok_q) mem[addr_q] <= quo_sat;
    if (cmd_i.mem_rd) scale_q <= mem[addr_q];
  end

  // multiply and output register
  logic signed [pcwd_pkg::ResW:0] prod;
  logic                           out_valid_q;

  assign prod = weight_q * $signed({1'b0, scale_q});
  assign status_o.out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      dequantized_o <= prod[pcwd_pkg::ResW-1:0];
      last_res_o    <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/per_channel_weight_dequantizer_unit.sv
// ----------------------------------------------------------------------------
// per_channel_weight_dequantizer_unit
// Dequantizes a stream of signed 8-bit weights by stored per-channel scales.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o): kind_i = 0 loads a Q16.16 scale
//    into entry scale_index_i, divided by (2^(bits-1)-1), stored Q8.24.
//    kind_i = 1 carries weight_i with last_i marking the tensor end.
//  - Output channel (out_valid_o / out_stall_i): one transaction per weight,
//    dequantized_o as signed Q16.24 plus last_res_o. Scale loads give none.
//  - Config port (cfg_we_i, cfg_idx_i, cfg_data_i): mode, bit length,
//    channel count, inner size; write only while idle.
// Sequence:
//  - Weight: capture, table read, then multiply into the output register;
//    no new input is accepted until the multiply has loaded the register.
//  - Scale load: the restoring divider yields one quotient bit per cycle
//    (40 quotient bits), followed by the table write.
// Reset: counters clear, config returns to its defaults, output goes empty;
//  the scale table holds garbage until loaded.
// Stall: the output register holds its transaction; the next input is still
//  accepted, and only the multiply step waits for the register to free up.
// ----------------------------------------------------------------------------
module per_channel_weight_dequantizer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [pcwd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pcwd_pkg::CfgW-1:0]           cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [9:0]                          scale_index_i,
  input  logic [pcwd_pkg::ScaleW-1:0]         scale_value_i,
  input  logic signed [pcwd_pkg::WeightW-1:0] weight_i,
  input  logic                                last_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pcwd_pkg::ResW-1:0]    dequantized_o,
  output logic                                last_res_o
);

  pcwd_pkg::cmd_t    cmd;
  pcwd_pkg::status_t status;

  // sequencer
  pcwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // counters, table, divider, multiplier
  pcwd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .scale_index_i (scale_index_i),
    .scale_value_i (scale_value_i),
    .weight_i      (weight_i),
    .last_i        (last_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .dequantized_o (dequantized_o),
    .last_res_o    (last_res_o)
  );

endmodule
